// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define CTRI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication under synchronous active-low reset.
`define CTRI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: rtl/core/ctri_pkg.sv
// Package: ring constants, config indices, operation codes, sequencer states and memory write bundle.
package ctri_pkg;

    localparam int RING_DEPTH = 64;
    localparam int SLOT_W     = $clog2(RING_DEPTH);

    typedef enum logic [1:0] {
        CFG_FULL_ALPHA     = 2'd0,
        CFG_FADE_STEP      = 2'd1,
        CFG_SPAWN_INTERVAL = 2'd2,
        CFG_SPRITE_SIZE    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_RENDER = 1'b1
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RDP, ST_PREV, ST_MX, ST_MY, ST_SUM, ST_SQRT, ST_WRS,
        ST_CHK, ST_MUL, ST_LDD, ST_DIV, ST_FIX, ST_WRI,
        ST_RRD, ST_RWT, ST_ROUT
    } t_state;

    typedef struct packed {
        logic              we_pt;
        logic              we_a;
        logic [SLOT_W-1:0] addr;
        logic [15:0]       x;
        logic [15:0]       y;
        logic [7:0]        a;
    } t_mem_wr;

endpackage

// File: rtl/core/ctri_in_if.sv
// Input channel: valid/ready handshake with a sample or render word.
interface ctri_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [11:0] cursor_x;
    logic [11:0] cursor_y;

    modport source (output valid, operation, cursor_x, cursor_y, input ready);
    modport sink   (input valid, operation, cursor_x, cursor_y, output ready);
endinterface

// File: rtl/core/ctri_out_if.sv
// Output channel: valid/ready handshake with one sprite word.
interface ctri_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] corner_x;
    logic signed [16:0] corner_y;
    logic [7:0]         alpha;
    logic               last_entry;

    modport source (output valid, corner_x, corner_y, alpha, last_entry, input ready);
    modport sink   (input valid, corner_x, corner_y, alpha, last_entry, output ready);
endinterface

// File: rtl/core/cursor_trail_ring_interpolator.sv
// Top level: trail ring sequencer with shared shift-subtract unit.
//   channel | dir | handshake     | word
//   i_in    | in  | valid/ready   | operation, cursor_x, cursor_y
//   o_out   | out | valid/ready   | corner_x, corner_y, alpha, last_entry
//   cfg     | in  | i_cfg_we only | i_cfg_idx, i_cfg_data
// A sample, once accepted, runs a 17-step square root, then two 34-step
// divides per interpolated point on one shift-subtract unit. A render tick
// fades each entry, writes it back and offers it, waiting on stalls. Reset is
// synchronous; ring valid bits clear at once. Input is taken only when idle;
// each sprite word holds in the output register until taken.
`include "assert_macros.svh"
module cursor_trail_ring_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctri_in_if.sink     i_in,
    ctri_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  ctri_pkg::t_cfg_idx i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import ctri_pkg::*;

    t_state r_state, n_state;
    logic [7:0]  r_full, r_fade, r_size;
    logic [15:0] r_spawn;
    logic [SLOT_W-1:0] r_slot, r_idx, rd_addr, prev_slot;
    t_mem_wr     wr;
    logic [15:0] rd_x, rd_y;
    logic [7:0]  rd_a, faded;
    logic [15:0] r_sx, r_sy, r_px, r_py, r_ax, r_ay, r_ix, r_iy;
    logic        r_negx, r_negy, r_axis;
    logic [32:0] r_prod, mul_res;
    logic [15:0] mul_a;
    logic [16:0] mul_b;
    logic [33:0] r_src, r_q;
    logic [18:0] r_rem;
    logic [16:0] r_dist;
    logic [17:0] r_d;
    logic [5:0]  r_cnt;
    logic [20:0] u_acc, u_trial, u_diff;
    logic        u_ge, is_sqrt;
    logic [16:0] dx, dy;
    logic [15:0] q16, fix_v;
    logic        r_ov, r_last;
    logic signed [16:0] r_cx, r_cy;
    logic [7:0]  r_oa;

    ctri_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_rd_addr(rd_addr),
        .o_rd_x   (rd_x),
        .o_rd_y   (rd_y),
        .o_rd_a   (rd_a)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= 8'd255;
            r_fade  <= 8'd8;
            r_spawn <= 16'd16;
            r_size  <= 8'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FULL_ALPHA:     r_full  <= i_cfg_data[7:0];
                CFG_FADE_STEP:      r_fade  <= i_cfg_data[7:0];
                CFG_SPAWN_INTERVAL: r_spawn <= i_cfg_data;
                CFG_SPRITE_SIZE:    r_size  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign prev_slot = (r_slot == '0) ? SLOT_W'(RING_DEPTH - 1) : r_slot - 1'b1;
    assign dx = {1'b0, r_sx} - {1'b0, rd_x};
    assign dy = {1'b0, r_sy} - {1'b0, rd_y};
    assign faded = (rd_a > r_fade) ? rd_a - r_fade : 8'd0;

    // Shared multiplier.
    always_comb begin
        mul_a = r_axis ? r_ay : r_ax;
        mul_b = r_d[16:0];
        if (r_state == ST_MX) begin
            mul_a = r_ax;
            mul_b = {1'b0, r_ax};
        end else if (r_state == ST_MY) begin
            mul_a = r_ay;
            mul_b = {1'b0, r_ay};
        end
    end
    assign mul_res = mul_a * mul_b;

    // Shared shift-subtract step: root digit or quotient bit.
    assign is_sqrt = (r_state == ST_SQRT);
    assign u_acc   = is_sqrt ? {r_rem, r_src[33:32]} : {2'b0, r_rem[17:0], r_src[33]};
    assign u_trial = is_sqrt ? {2'b0, r_q[16:0], 2'b01} : {4'b0, r_dist};
    assign u_ge    = (u_acc >= u_trial);
    assign u_diff  = u_acc - u_trial;

    assign q16   = r_q[15:0];
    assign fix_v = (r_axis ? r_negy : r_negx)
                 ? (r_axis ? r_py : r_px) - q16 : (r_axis ? r_py : r_px) + q16;

    // Next state, memory access and handshake.
    always_comb begin
        n_state    = r_state;
        rd_addr    = r_idx;
        wr.we_pt   = 1'b0;
        wr.we_a    = 1'b0;
        wr.addr    = r_slot;
        wr.x       = r_sx;
        wr.y       = r_sy;
        wr.a       = r_full;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.operation == OP_RENDER) ? ST_RRD : ST_RDP;
                end
            end
            ST_RDP: begin
                rd_addr = prev_slot;
                n_state = ST_PREV;
            end
            ST_PREV: n_state = ST_MX;
            ST_MX:   n_state = ST_MY;
            ST_MY:   n_state = ST_SUM;
            ST_SUM:  n_state = ST_SQRT;
            ST_SQRT: if (r_cnt == 6'd16) n_state = ST_WRS;
            ST_WRS: begin
                wr.we_pt = 1'b1;
                n_state  = ST_CHK;
            end
            ST_CHK: begin
                if (r_spawn != 16'd0 && r_dist != 17'd0 && r_d < {1'b0, r_dist}) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL: n_state = ST_LDD;
            ST_LDD: n_state = ST_DIV;
            ST_DIV: if (r_cnt == 6'd33) n_state = ST_FIX;
            ST_FIX: n_state = r_axis ? ST_WRI : ST_MUL;
            ST_WRI: begin
                wr.we_pt = 1'b1;
                wr.x     = r_ix;
                wr.y     = r_iy;
                n_state  = ST_CHK;
            end
            ST_RRD: n_state = ST_RWT;
            ST_RWT: begin
                wr.we_a = 1'b1;
                wr.addr = r_idx;
                wr.a    = faded;
                n_state = ST_ROUT;
            end
            ST_ROUT: begin
                if (o_out.ready) begin
                    n_state = (r_idx == SLOT_W'(RING_DEPTH - 1)) ? ST_IDLE : ST_RRD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            r_idx   <= '0;
            r_axis  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr.we_pt) begin
                r_slot <= (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
            end
            if (r_state == ST_IDLE) r_idx <= '0;
            if (r_state == ST_ROUT && o_out.ready && r_idx != SLOT_W'(RING_DEPTH - 1)) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == ST_FIX) r_axis <= ~r_axis;
            if (r_state == ST_RWT) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_sx <= {i_in.cursor_x, 4'b0};
                r_sy <= {i_in.cursor_y, 4'b0};
            end
            ST_PREV: begin
                r_px   <= rd_x;
                r_py   <= rd_y;
                r_negx <= dx[16];
                r_negy <= dy[16];
                r_ax   <= dx[16] ? 16'(-dx) : dx[15:0];
                r_ay   <= dy[16] ? 16'(-dy) : dy[15:0];
            end
            ST_MX: r_prod <= mul_res;
            ST_MY: begin
                r_src  <= {1'b0, r_prod};
                r_prod <= mul_res;
            end
            ST_SUM: begin
                r_src <= r_src + {1'b0, r_prod};
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
            end
            ST_SQRT: begin
                r_rem <= u_ge ? u_diff[18:0] : u_acc[18:0];
                r_q   <= {r_q[32:0], u_ge};
                r_src <= {r_src[31:0], 2'b00};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_WRS: begin
                r_dist <= r_q[16:0];
                r_d    <= {2'b0, r_spawn};
            end
            ST_MUL: r_prod <= mul_res;
            ST_LDD: begin
                r_src <= {1'b0, r_prod};
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= u_ge ? u_diff[18:0] : u_acc[18:0];
                r_q   <= {r_q[32:0], u_ge};
                r_src <= {r_src[32:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_FIX: begin
                if (r_axis) r_iy <= fix_v;
                else        r_ix <= fix_v;
            end
            ST_WRI: r_d <= r_d + {2'b0, r_spawn};
            ST_RWT: begin
                r_cx   <= $signed({1'b0, rd_x}) - $signed({6'b0, r_size, 3'b0});
                r_cy   <= $signed({1'b0, rd_y}) - $signed({6'b0, r_size, 3'b0});
                r_oa   <= faded;
                r_last <= (r_idx == SLOT_W'(RING_DEPTH - 1));
            end
            default: ;
        endcase
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.corner_x   = r_cx;
    assign o_out.corner_y   = r_cy;
    assign o_out.alpha      = r_oa;
    assign o_out.last_entry = r_last;

    // Input is never taken while a word waits at the output.
    `CTRI_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, i_in.ready, !o_out.valid)
    // An accepted sample starts with the previous-point read.
    `CTRI_ASSERT_NEXT(a_sample_start, i_clk, i_rst_n,
        i_in.valid && i_in.ready && i_in.operation == OP_SAMPLE, r_state == ST_RDP)
    // A delivered last entry ends the render run.
    `CTRI_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n,
        o_out.valid && o_out.ready && o_out.last_entry, r_state == ST_IDLE)
endmodule

// File: rtl/core/ctri_ring.sv
// Trail point memory with per-entry valid bits and registered read.
module ctri_ring (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ctri_pkg::t_mem_wr       i_wr,
    input  logic [ctri_pkg::SLOT_W-1:0] i_rd_addr,
    output logic [15:0]             o_rd_x,
    output logic [15:0]             o_rd_y,
    output logic [7:0]              o_rd_a
);
    import ctri_pkg::*;

    logic [15:0] mem_x [RING_DEPTH];
    logic [15:0] mem_y [RING_DEPTH];
    logic [7:0]  mem_a [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_valid;
    logic [15:0] r_rd_x;
    logic [15:0] r_rd_y;
    logic [7:0]  r_rd_a;
    logic        r_rd_v;

    // Write point fields or alpha alone.
    always_ff @(posedge i_clk) begin
        if (i_wr.we_pt) begin
            mem_x[i_wr.addr] <= i_wr.x;
            mem_y[i_wr.addr] <= i_wr.y;
        end
        if (i_wr.we_pt || i_wr.we_a) begin
            mem_a[i_wr.addr] <= i_wr.a;
        end
        r_rd_x <= mem_x[i_rd_addr];
        r_rd_y <= mem_y[i_rd_addr];
        r_rd_a <= mem_a[i_rd_addr];
    end

    // Track entries written since reset; others read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            if (i_wr.we_pt) r_valid[i_wr.addr] <= 1'b1;
            r_rd_v <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_x = r_rd_v ? r_rd_x : 16'd0;
    assign o_rd_y = r_rd_v ? r_rd_y : 16'd0;
    assign o_rd_a = r_rd_v ? r_rd_a : 8'd0;
endmodule
